// ----- hdl/mm_pkg.sv -----
// shared types, constants and command/status structs for the matrix multiply core
// no dependencies; used by mm_ctrl, mm_dpath and matrix_multiply_core
`default_nettype none

package mm_pkg;

    // matrix geometry
    localparam int MAX_DIM  = 8;
    localparam int IDX_W    = $clog2(MAX_DIM);
    localparam int DIM_W    = 4;
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_DIM * MAX_DIM;

    // arithmetic widths
    localparam int VAL_W    = 16;
    localparam int MUL_W    = 2 * VAL_W;
    localparam int ACC_W    = 35;

    // stream widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;
    localparam int OP_W       = 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

    // input word kinds
    typedef enum logic [OP_W-1:0] {
        OP_WR_A    = 2'd0,
        OP_WR_B    = 2'd1,
        OP_COMPUTE = 2'd2
    } t_opcode;

    // controller to datapath
    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic              rd_en;
        logic              rd_first;
        logic [IDX_W-1:0]  rd_i;
        logic [IDX_W-1:0]  rd_j;
        logic [IDX_W-1:0]  rd_k;
        logic              push;
        logic              push_last;
        logic              push_err;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hdl/mm_dpath.sv -----
// datapath: A and B element memories, multiply-accumulate pipeline, output register
// depends on mm_pkg; driven by mm_ctrl through t_dp_cmd
`default_nettype none

module mm_dpath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire mm_pkg::t_dp_cmd                   i_cmd,
    output mm_pkg::t_dp_status                     o_status,
    input  wire logic [mm_pkg::IDX_W-1:0]          i_wr_row,
    input  wire logic [mm_pkg::IDX_W-1:0]          i_wr_col,
    input  wire logic [mm_pkg::VAL_W-1:0]          i_wr_value,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [mm_pkg::ACC_W-1:0]        o_product,
    output logic [mm_pkg::IDX_W-1:0]               o_out_row,
    output logic [mm_pkg::IDX_W-1:0]               o_out_col,
    output logic                                   o_last,
    output logic                                   o_shape_error
);

    logic [mm_pkg::VAL_W-1:0] r_a_mem [mm_pkg::DEPTH];
    logic [mm_pkg::VAL_W-1:0] r_b_mem [mm_pkg::DEPTH];

    logic signed [mm_pkg::VAL_W-1:0] r_a_q, r_b_q;
    logic                            r_v1, r_first1;
    logic signed [mm_pkg::MUL_W-1:0] r_prod;
    logic                            r_v2, r_first2;
    logic signed [mm_pkg::ACC_W-1:0] r_acc;
    logic signed [mm_pkg::ACC_W-1:0] n_acc;
    logic signed [mm_pkg::ACC_W-1:0] w_prod_ext;

    logic                            r_out_valid;
    logic signed [mm_pkg::ACC_W-1:0] r_product;
    logic [mm_pkg::IDX_W-1:0]        r_out_row, r_out_col;
    logic                            r_last, r_err;

    // element loads and operand reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_a_mem[{i_wr_row, i_wr_col}] <= i_wr_value;
        end
        if (i_cmd.wr_b) begin
            r_b_mem[{i_wr_row, i_wr_col}] <= i_wr_value;
        end
        if (i_cmd.rd_en) begin
            r_a_q <= r_a_mem[{i_cmd.rd_i, i_cmd.rd_k}];
            r_b_q <= r_b_mem[{i_cmd.rd_k, i_cmd.rd_j}];
        end
    end

    // accumulate step
    always_comb begin
        w_prod_ext = {{(mm_pkg::ACC_W-mm_pkg::MUL_W){r_prod[mm_pkg::MUL_W-1]}}, r_prod};
        n_acc      = r_first2 ? w_prod_ext : r_acc + w_prod_ext;
    end

    // multiply and accumulate stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
        end
        r_first1 <= i_cmd.rd_first;
        r_first2 <= r_first1;
        if (r_v1) begin
            r_prod <= r_a_q * r_b_q;
        end
        if (r_v2) begin
            r_acc <= n_acc;
        end
    end

    // output register, loaded on push; mm_ctrl pushes only when it is free or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.push) begin
            r_product <= i_cmd.push_err ? '0 : r_acc;
            r_out_row <= i_cmd.push_err ? '0 : i_cmd.rd_i;
            r_out_col <= i_cmd.push_err ? '0 : i_cmd.rd_j;
            r_last    <= i_cmd.push_last;
            r_err     <= i_cmd.push_err;
        end
    end

    assign o_status.pipe_busy = r_v1 | r_v2;
    assign o_status.out_free  = ~r_out_valid | i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_product     = r_product;
    assign o_out_row     = r_out_row;
    assign o_out_col     = r_out_col;
    assign o_last        = r_last;
    assign o_shape_error = r_err;

endmodule

`default_nettype wire

// ----- hdl/mm_ctrl.sv -----
// controller: shape registers, input word decode and the element/dot-product sequencer
// depends on mm_pkg; commands mm_dpath through t_dp_cmd
`default_nettype none

module mm_ctrl (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [mm_pkg::DIM_W-1:0]          i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [mm_pkg::OP_W-1:0]           i_opcode,
    input  wire mm_pkg::t_dp_status                i_status,
    output mm_pkg::t_dp_cmd                        o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_ERR
    } t_state;

    t_state r_state, n_state;
    logic [mm_pkg::DIM_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [mm_pkg::IDX_W-1:0] r_i, r_j, r_k, n_i, n_j, n_k;
    logic [mm_pkg::DIM_W-1:0] w_m, w_n, w_p, w_q;
    logic                     w_accept;
    logic                     w_k_end, w_j_end, w_i_end;

    // out-of-range sizes: zero reads as one, above the max reads as the max
    function automatic logic [mm_pkg::DIM_W-1:0] clamp_dim(input logic [mm_pkg::DIM_W-1:0] d);
        logic [mm_pkg::DIM_W-1:0] res;
        if (d == '0) begin
            res = mm_pkg::DIM_W'(1);
        end else if (d > mm_pkg::DIM_W'(mm_pkg::MAX_DIM)) begin
            res = mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
        end else begin
            res = d;
        end
        return res;
    endfunction

    assign w_m = clamp_dim(r_a_rows);
    assign w_n = clamp_dim(r_a_cols);
    assign w_p = clamp_dim(r_b_rows);
    assign w_q = clamp_dim(r_b_cols);

    assign w_k_end = ({1'b0, r_k} == w_n - mm_pkg::DIM_W'(1));
    assign w_j_end = ({1'b0, r_j} == w_q - mm_pkg::DIM_W'(1));
    assign w_i_end = ({1'b0, r_i} == w_m - mm_pkg::DIM_W'(1));

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid & o_in_ready;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.rd_i = r_i;
        o_cmd.rd_j = r_j;
        o_cmd.rd_k = r_k;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (mm_pkg::t_opcode'(i_opcode))
                        mm_pkg::OP_WR_A: o_cmd.wr_a = 1'b1;
                        mm_pkg::OP_WR_B: o_cmd.wr_b = 1'b1;
                        mm_pkg::OP_COMPUTE: begin
                            n_i = '0;
                            n_j = '0;
                            n_k = '0;
                            n_state = (w_n != w_p) ? S_ERR : S_MAC;
                        end
                        default: ;
                    endcase
                end
            end
            S_MAC: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_first = (r_k == '0);
                if (w_k_end) begin
                    n_k     = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + mm_pkg::IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy && i_status.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = w_i_end & w_j_end;
                    if (w_i_end && w_j_end) begin
                        n_state = S_IDLE;
                    end else if (w_j_end) begin
                        n_j     = '0;
                        n_i     = r_i + mm_pkg::IDX_W'(1);
                        n_state = S_MAC;
                    end else begin
                        n_j     = r_j + mm_pkg::IDX_W'(1);
                        n_state = S_MAC;
                    end
                end
            end
            S_ERR: begin
                if (i_status.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = 1'b1;
                    o_cmd.push_err  = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, loop counters and shape registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_a_rows <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
            r_a_cols <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
            r_b_rows <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
            r_b_cols <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mm_pkg::REG_A_ROWS: r_a_rows <= i_cfg_data;
                    mm_pkg::REG_A_COLS: r_a_cols <= i_cfg_data;
                    mm_pkg::REG_B_ROWS: r_b_rows <= i_cfg_data;
                    mm_pkg::REG_B_COLS: r_b_cols <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/matrix_multiply_core.sv -----
// loads: a load word leaves the core idle, so it takes the next word right after it
// compute: each element of C takes n operand reads, two pipeline stages (multiply and
// accumulate) and one hand-off to the output register; the hand-off waits while the
// output register is full, so a stalled output side holds up the product
// reset: synchronous active low; shape registers return to 8, element memories hold
// stale contents and must be loaded before use
`default_nettype none

module matrix_multiply_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration write port
    input  wire logic                                 i_cfg_we,
    input  wire logic [mm_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [mm_pkg::DIM_W-1:0]             i_cfg_data,
    // input stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [mm_pkg::IN_DATA_W-1:0]         s_axis_tdata,  // row, col, value, pad
    input  wire logic [mm_pkg::OP_W-1:0]              s_axis_tuser,  // opcode
    // result stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [mm_pkg::OUT_DATA_W-1:0]             m_axis_tdata,  // product, out_row, out_col, pad
    output logic                                      m_axis_tlast,
    output logic                                      m_axis_tuser   // shape_error
);

    mm_pkg::t_dp_cmd    w_cmd;
    mm_pkg::t_dp_status w_status;

    logic signed [mm_pkg::ACC_W-1:0] w_product;
    logic [mm_pkg::IDX_W-1:0]        w_out_row, w_out_col;

    // input word fields
    logic [mm_pkg::IDX_W-1:0] w_row, w_col;
    logic [mm_pkg::VAL_W-1:0] w_value;
    assign w_row   = s_axis_tdata[mm_pkg::IDX_W-1:0];
    assign w_col   = s_axis_tdata[2*mm_pkg::IDX_W-1:mm_pkg::IDX_W];
    assign w_value = s_axis_tdata[2*mm_pkg::IDX_W+mm_pkg::VAL_W-1:2*mm_pkg::IDX_W];

    mm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_opcode   (s_axis_tuser),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mm_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_wr_row      (w_row),
        .i_wr_col      (w_col),
        .i_wr_value    (w_value),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_product     (w_product),
        .o_out_row     (w_out_row),
        .o_out_col     (w_out_col),
        .o_last        (m_axis_tlast),
        .o_shape_error (m_axis_tuser)
    );

    // result word packing
    assign m_axis_tdata = {
        (mm_pkg::OUT_DATA_W - mm_pkg::ACC_W - 2*mm_pkg::IDX_W)'(0),
        w_out_col, w_out_row, w_product
    };

    // error word is always a single last word with zero payload
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && w_product == '0))
        else $error("shape error word without last or with nonzero product");

    // the sequencer never overwrites a result that is still waiting
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> w_status.out_free)
        else $error("result pushed into a full output register");

    // no new word is taken while operand reads are in flight
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.rd_en || w_status.pipe_busy) |-> !s_axis_tready)
        else $error("input accepted during a dot product");

endmodule

`default_nettype wire

// ----- test/matrix_multiply_core_test.sv -----
// self-checking testbench for matrix_multiply_core: loads A and B, computes products, checks C
// depends on mm_pkg and matrix_multiply_core; holds its own product predictor
`timescale 1ns / 100ps

module matrix_multiply_core_test;

    localparam int CLK_PERIOD  = 10;
    localparam int POST_CYCLES = 8;
    localparam int HOLD_LEN    = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int WORD_TARGET = 280;

    // opcode that the core must ignore
    localparam logic [mm_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [mm_pkg::OP_W-1:0]  op;
        logic [mm_pkg::IDX_W-1:0] row;
        logic [mm_pkg::IDX_W-1:0] col;
        logic [mm_pkg::VAL_W-1:0] value;
    } t_load_word;

    typedef struct {
        logic [mm_pkg::ACC_W-1:0] product;
        logic [mm_pkg::IDX_W-1:0] row;
        logic [mm_pkg::IDX_W-1:0] col;
        logic                     last;
        logic                     err;
    } t_c_elem;

    // dut signals
    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_we      = 1'b0;
    logic [mm_pkg::CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [mm_pkg::DIM_W-1:0]      i_cfg_data    = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [mm_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;  // row, col, value, pad
    logic [mm_pkg::OP_W-1:0]       s_axis_tuser  = '0;  // opcode
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [mm_pkg::OUT_DATA_W-1:0] m_axis_tdata;        // product, out_row, out_col, pad
    logic                          m_axis_tlast;
    logic                          m_axis_tuser;        // shape_error

    // stimulus and scoreboard state
    t_load_word pending_words[$];
    t_c_elem    c_elems_due[$];
    t_load_word next_word;
    t_c_elem    due;

    int send_idle_pct = 19;
    int recv_idle_pct = 46;
    logic long_hold_req = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_cnt      = 0;
    int   quiet_cycles  = 0;

    // which elements the stimulus has already queued a load for
    bit a_loaded [mm_pkg::DEPTH];
    bit b_loaded [mm_pkg::DEPTH];
    int queued = 0;

    // predictor copy of the shape registers and element stores
    logic [mm_pkg::DIM_W-1:0] shape_a_rows = 4'd8;
    logic [mm_pkg::DIM_W-1:0] shape_a_cols = 4'd8;
    logic [mm_pkg::DIM_W-1:0] shape_b_rows = 4'd8;
    logic [mm_pkg::DIM_W-1:0] shape_b_cols = 4'd8;
    logic [mm_pkg::VAL_W-1:0] a_elems [mm_pkg::DEPTH];
    logic [mm_pkg::VAL_W-1:0] b_elems [mm_pkg::DEPTH];

    int mismatches   = 0;
    int words_taken  = 0;
    int results_seen = 0;
    int computes     = 0;
    int shape_errs   = 0;

    matrix_multiply_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // out-of-range register values clamp to 1..MAX_DIM
    function automatic int eff_dim(logic [mm_pkg::DIM_W-1:0] r);
        if (r == 0) return 1;
        if (r > mm_pkg::MAX_DIM) return mm_pkg::MAX_DIM;
        return int'(r);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("mismatch on %s at %0t: got %0h, want %0h", what, $time, got, want);
    endtask

    // update stores on loads; on compute, queue every element of C or one error word
    task automatic predict_c_elements(logic [mm_pkg::OP_W-1:0] op, logic [mm_pkg::IDX_W-1:0] r,
                                      logic [mm_pkg::IDX_W-1:0] c,
                                      logic [mm_pkg::VAL_W-1:0] v);
        int m, n, p, q, i, j, k;
        longint acc;
        t_c_elem e;
        if (op == mm_pkg::OP_WR_A) begin
            a_elems[{r, c}] = v;
        end else if (op == mm_pkg::OP_WR_B) begin
            b_elems[{r, c}] = v;
        end else if (op == mm_pkg::OP_COMPUTE) begin
            computes++;
            m = eff_dim(shape_a_rows);
            n = eff_dim(shape_a_cols);
            p = eff_dim(shape_b_rows);
            q = eff_dim(shape_b_cols);
            if (n != p) begin
                shape_errs++;
                e.product = '0;
                e.row     = '0;
                e.col     = '0;
                e.last    = 1'b1;
                e.err     = 1'b1;
                c_elems_due = {c_elems_due, e};
            end else begin
                for (i = 0; i < m; i++) begin
                    for (j = 0; j < q; j++) begin
                        acc = 0;
                        for (k = 0; k < n; k++)
                            acc += longint'($signed(a_elems[i * mm_pkg::MAX_DIM + k])) *
                                   longint'($signed(b_elems[k * mm_pkg::MAX_DIM + j]));
                        e.product = acc[mm_pkg::ACC_W-1:0];
                        e.row     = mm_pkg::IDX_W'(i);
                        e.col     = mm_pkg::IDX_W'(j);
                        e.last    = (i == m - 1) && (j == q - 1);
                        e.err     = 1'b0;
                        c_elems_due = {c_elems_due, e};
                    end
                end
            end
        end
    endtask

    // input driver: next word goes out once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_word = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, next_word.value, next_word.col, next_word.row};
                s_axis_tuser  <= next_word.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side ready, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (long_hold_req && !hold_done) begin
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        m_axis_tready <= (hold_cnt == 0) && !(long_hold_req && !hold_done) &&
                         ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: track register writes, predict on accepted words, check result words
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_we) begin
            case (i_cfg_idx)
                mm_pkg::REG_A_ROWS: shape_a_rows = i_cfg_data;
                mm_pkg::REG_A_COLS: shape_a_cols = i_cfg_data;
                mm_pkg::REG_B_ROWS: shape_b_rows = i_cfg_data;
                mm_pkg::REG_B_COLS: shape_b_cols = i_cfg_data;
                default: ;
            endcase
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            words_taken++;
            predict_c_elements(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[5:3],
                               s_axis_tdata[21:6]);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (c_elems_due.size() == 0) begin
                report_mismatch("unexpected result word", longint'(m_axis_tdata), 0);
            end else begin
                due = c_elems_due.pop_front();
                if (m_axis_tdata[34:0] !== due.product)
                    report_mismatch("product", longint'(m_axis_tdata[34:0]),
                                    longint'(due.product));
                if (m_axis_tdata[37:35] !== due.row)
                    report_mismatch("out_row", longint'(m_axis_tdata[37:35]),
                                    longint'(due.row));
                if (m_axis_tdata[40:38] !== due.col)
                    report_mismatch("out_col", longint'(m_axis_tdata[40:38]),
                                    longint'(due.col));
                if (m_axis_tlast !== due.last)
                    report_mismatch("last", longint'(m_axis_tlast), longint'(due.last));
                if (m_axis_tuser !== due.err)
                    report_mismatch("shape_error", longint'(m_axis_tuser), longint'(due.err));
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // mostly small dimensions, the largest only early so the word count stays near target
    function automatic int pick_dim();
        if (queued < WORD_TARGET / 2 && $urandom_range(9) == 0) return mm_pkg::MAX_DIM;
        return $urandom_range(1, 4);
    endfunction

    // register encoding for a dimension, using the clamped codes at the ends
    function automatic logic [mm_pkg::DIM_W-1:0] raw_dim(int d);
        if (d == 1 && $urandom_range(1)) return '0;
        if (d == mm_pkg::MAX_DIM && $urandom_range(1))
            return mm_pkg::DIM_W'($urandom_range(15, 9));
        return mm_pkg::DIM_W'(d);
    endfunction

    task automatic queue_word(logic [mm_pkg::OP_W-1:0] op, logic [mm_pkg::IDX_W-1:0] r,
                              logic [mm_pkg::IDX_W-1:0] c, logic [mm_pkg::VAL_W-1:0] v);
        t_load_word w;
        w.op    = op;
        w.row   = r;
        w.col   = c;
        w.value = v;
        pending_words = {pending_words, w};
        if (op == mm_pkg::OP_WR_A) a_loaded[{r, c}] = 1'b1;
        if (op == mm_pkg::OP_WR_B) b_loaded[{r, c}] = 1'b1;
        if (op != OP_RESERVED) queued++;
    endtask

    // overwrite one element inside the region the current shape reads
    task automatic queue_rewrite(int m, int n, int q);
        if ($urandom_range(1))
            queue_word(mm_pkg::OP_WR_A, mm_pkg::IDX_W'($urandom_range(0, m - 1)),
                       mm_pkg::IDX_W'($urandom_range(0, n - 1)), mm_pkg::VAL_W'($urandom));
        else
            queue_word(mm_pkg::OP_WR_B, mm_pkg::IDX_W'($urandom_range(0, n - 1)),
                       mm_pkg::IDX_W'($urandom_range(0, q - 1)), mm_pkg::VAL_W'($urandom));
    endtask

    // wait until no word is pending and no result is due, then let the core settle
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || s_axis_tvalid || c_elems_due.size() != 0);
        repeat (POST_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [mm_pkg::CFG_IDX_W-1:0] idx,
                             logic [mm_pkg::DIM_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    // shape registers change only while the core is idle
    task automatic set_shape(logic [mm_pkg::DIM_W-1:0] ar, logic [mm_pkg::DIM_W-1:0] ac,
                             logic [mm_pkg::DIM_W-1:0] br, logic [mm_pkg::DIM_W-1:0] bc);
        wait_quiet();
        cfg_write(mm_pkg::REG_A_ROWS, ar);
        cfg_write(mm_pkg::REG_A_COLS, ac);
        cfg_write(mm_pkg::REG_B_ROWS, br);
        cfg_write(mm_pkg::REG_B_COLS, bc);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // stimulus
    initial begin : stimulus
        int   m, n, p, q, i, j, k, phase;
        logic hold_phase;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: clamped shape mismatch
        set_shape(4'd0, 4'd1, 4'd15, 4'd2);
        queue_word(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000);

        // directed: 1x1 extremes and the reserved opcode
        set_shape(4'd1, 4'd1, 4'd1, 4'd1);
        queue_word(mm_pkg::OP_WR_A, 3'd0, 3'd0, 16'h8000);
        queue_word(mm_pkg::OP_WR_B, 3'd0, 3'd0, 16'h8000);
        queue_word(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
        queue_word(OP_RESERVED, 3'd7, 3'd7, 16'hFFFF);
        queue_word(mm_pkg::OP_WR_A, 3'd0, 3'd0, 16'h7FFF);
        queue_word(mm_pkg::OP_COMPUTE, 3'd7, 3'd7, 16'hFFFF);
        queue_word(OP_RESERVED, 3'd0, 3'd0, 16'h0000);

        // directed: matrix-vector with sums past 32 bits, far corner written
        set_shape(4'd2, 4'd2, 4'd2, 4'd1);
        queue_word(mm_pkg::OP_WR_A, 3'd7, 3'd7, 16'h0001);
        queue_word(mm_pkg::OP_WR_B, 3'd7, 3'd7, 16'hFFFF);
        for (i = 0; i < 2; i++) begin
            queue_word(mm_pkg::OP_WR_B, mm_pkg::IDX_W'(i), 3'd0, 16'h8000);
            for (k = 0; k < 2; k++)
                queue_word(mm_pkg::OP_WR_A, mm_pkg::IDX_W'(i), mm_pkg::IDX_W'(k), 16'h8000);
        end
        queue_word(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000);

        // random phases: mostly well-formed load-then-compute runs
        phase = 0;
        while (queued < WORD_TARGET) begin
            phase++;
            hold_phase = (phase == 3);
            m = pick_dim();
            n = pick_dim();
            q = pick_dim();
            p = n;
            if (!hold_phase && $urandom_range(99) < 15) begin
                while (p == n) p = pick_dim();
            end
            if (hold_phase) begin
                m = 4;
                n = 3;
                p = 3;
                q = 4;
            end
            set_shape(raw_dim(m), raw_dim(n), raw_dim(p), raw_dim(q));
            if (queued < 120) begin
                send_idle_pct = 19;
                recv_idle_pct = 46;
            end else if (queued < 210) begin
                send_idle_pct = 46;
                recv_idle_pct = 19;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (hold_phase) long_hold_req = 1'b1;

            if (n == p) begin
                for (i = 0; i < m; i++)
                    for (k = 0; k < n; k++)
                        if (!a_loaded[i * mm_pkg::MAX_DIM + k])
                            queue_word(mm_pkg::OP_WR_A, mm_pkg::IDX_W'(i), mm_pkg::IDX_W'(k),
                                       mm_pkg::VAL_W'($urandom));
                for (k = 0; k < n; k++)
                    for (j = 0; j < q; j++)
                        if (!b_loaded[k * mm_pkg::MAX_DIM + j])
                            queue_word(mm_pkg::OP_WR_B, mm_pkg::IDX_W'(k), mm_pkg::IDX_W'(j),
                                       mm_pkg::VAL_W'($urandom));
                repeat ($urandom_range(0, 3)) queue_rewrite(m, n, q);
            end else begin
                // broken run: scattered loads anywhere in the stores
                repeat ($urandom_range(0, 3))
                    queue_word($urandom_range(1) ? mm_pkg::OP_WR_A : mm_pkg::OP_WR_B,
                               mm_pkg::IDX_W'($urandom), mm_pkg::IDX_W'($urandom),
                               mm_pkg::VAL_W'($urandom));
            end
            if ($urandom_range(9) == 0)
                queue_word(OP_RESERVED, mm_pkg::IDX_W'($urandom), mm_pkg::IDX_W'($urandom),
                           mm_pkg::VAL_W'($urandom));
            queue_word(mm_pkg::OP_COMPUTE, mm_pkg::IDX_W'($urandom), mm_pkg::IDX_W'($urandom),
                       mm_pkg::VAL_W'($urandom));
            // during the hold-off the sender keeps offering loads behind the compute
            if (hold_phase) repeat (6) queue_rewrite(m, n, q);
        end

        wait_quiet();
        $display("covered %0d accepted words, %0d computes (%0d with shape errors)",
                 words_taken, computes, shape_errs);
        $display("checked %0d result words, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
